### rtl/suid_pkg.sv
package suid_pkg;

    localparam logic OP_UNION     = 1'b0;
    localparam logic OP_INTERSECT = 1'b1;

    typedef enum logic {
        SEL_RES,
        SEL_REF
    } store_sel_t;

    typedef struct packed {
        logic       load;
        logic       scan_start;
        store_sel_t scan_sel;
        logic       res_append;
        logic       ref_append;
        logic       emit;
        logic       emit_ovf;
    } cmd_t;

    typedef struct packed {
        logic scan_done;
        logic hit;
        logic res_full;
        logic ref_full;
        logic second;
        logic op_kind;
        logic out_free;
    } status_t;

endpackage

### rtl/suid_ctrl.sv
module suid_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  suid_pkg::status_t status,
    output suid_pkg::cmd_t    cmd
);
    import suid_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_KICK,
        ST_SCAN,
        ST_EMIT
    } state_t;

    state_t     state_reg, state_next;
    store_sel_t sel_reg, sel_next;
    logic       ovf_reg, ovf_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            sel_reg   <= SEL_RES;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
            ovf_reg   <= ovf_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        sel_next   = sel_reg;
        ovf_next   = ovf_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_KICK;
                end
            end
            ST_KICK:
            begin
                cmd.scan_start = 1'b1;
                cmd.scan_sel   = (status.op_kind == OP_INTERSECT) ? SEL_REF : SEL_RES;
                sel_next       = cmd.scan_sel;
                state_next     = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (status.scan_done)
                begin
                    if (sel_reg == SEL_RES)
                    begin
                        if (status.hit)
                            state_next = ST_IDLE;
                        else
                        begin
                            ovf_next   = status.res_full;
                            state_next = ST_EMIT;
                        end
                    end
                    else if (status.second)
                    begin
                        if (status.hit)
                            state_next = ST_IDLE;
                        else if (status.ref_full)
                        begin
                            ovf_next   = 1'b1;
                            state_next = ST_EMIT;
                        end
                        else
                        begin
                            cmd.ref_append = 1'b1;
                            state_next     = ST_IDLE;
                        end
                    end
                    else if (!status.hit)
                        state_next = ST_IDLE;
                    else
                    begin
                        // first-operand item present in reference: check result
                        cmd.scan_start = 1'b1;
                        cmd.scan_sel   = SEL_RES;
                        sel_next       = SEL_RES;
                    end
                end
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit       = 1'b1;
                    cmd.emit_ovf   = ovf_reg;
                    cmd.res_append = !ovf_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### rtl/suid_datapath.sv
module suid_datapath #(
    parameter int RESULT_DEPTH    = 64,
    parameter int REFERENCE_DEPTH = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_wdata,
    input  logic [31:0]       s_tdata,
    input  logic [1:0]        s_tuser,
    input  logic              m_tready,
    output logic              m_tvalid,
    output logic [31:0]       m_tdata,
    output logic              m_tuser,
    input  suid_pkg::cmd_t    cmd,
    output suid_pkg::status_t status
);
    import suid_pkg::*;

    localparam int RCW = $clog2(RESULT_DEPTH + 1);
    localparam int FCW = $clog2(REFERENCE_DEPTH + 1);
    localparam int RAW = $clog2(RESULT_DEPTH);
    localparam int FAW = $clog2(REFERENCE_DEPTH);
    localparam int CW  = (RCW > FCW) ? RCW : FCW;

    logic [31:0] res_mem [RESULT_DEPTH];
    logic [31:0] ref_mem [REFERENCE_DEPTH];

    logic             op_kind_reg;
    logic [31:0]      value_reg;
    logic             second_reg;
    logic [RCW-1:0]   res_cnt_reg;
    logic [FCW-1:0]   ref_cnt_reg;
    store_sel_t       sel_reg;
    logic             scanning_reg;
    logic [CW-1:0]    idx_reg;
    logic             rd_valid_reg;
    logic             hit_reg;
    logic [31:0]      res_rdata_reg;
    logic [31:0]      ref_rdata_reg;
    logic             out_valid_reg;
    logic [31:0]      out_data_reg;
    logic             out_ovf_reg;

    logic [CW-1:0]    limit;
    logic [31:0]      rdata;
    logic             issue;
    logic             scan_done;
    logic             out_free;

    assign limit     = (sel_reg == SEL_REF) ? CW'(ref_cnt_reg) : CW'(res_cnt_reg);
    assign rdata     = (sel_reg == SEL_REF) ? ref_rdata_reg : res_rdata_reg;
    assign issue     = scanning_reg && (idx_reg < limit);
    assign scan_done = scanning_reg && !issue && !rd_valid_reg;
    assign out_free  = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_kind_reg   <= OP_UNION;
            res_cnt_reg   <= '0;
            ref_cnt_reg   <= '0;
            sel_reg       <= SEL_RES;
            scanning_reg  <= 1'b0;
            idx_reg       <= '0;
            rd_valid_reg  <= 1'b0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                op_kind_reg <= cfg_wdata;

            if (cmd.load && s_tuser[1])
            begin
                res_cnt_reg <= '0;
                ref_cnt_reg <= '0;
            end
            if (cmd.res_append)
                res_cnt_reg <= res_cnt_reg + RCW'(1);
            if (cmd.ref_append)
                ref_cnt_reg <= ref_cnt_reg + FCW'(1);

            if (cmd.scan_start)
            begin
                scanning_reg <= 1'b1;
                idx_reg      <= '0;
                rd_valid_reg <= 1'b0;
                hit_reg      <= 1'b0;
                sel_reg      <= cmd.scan_sel;
            end
            else if (scanning_reg)
            begin
                rd_valid_reg <= issue;
                if (issue)
                    idx_reg <= idx_reg + CW'(1);
                if (rd_valid_reg && (rdata == value_reg))
                    hit_reg <= 1'b1;
                if (scan_done)
                    scanning_reg <= 1'b0;
            end

            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            value_reg  <= s_tdata;
            second_reg <= s_tuser[0];
        end
        if (cmd.emit)
        begin
            out_data_reg <= value_reg;
            out_ovf_reg  <= cmd.emit_ovf;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_append)
            res_mem[res_cnt_reg[RAW-1:0]] <= value_reg;
        res_rdata_reg <= res_mem[idx_reg[RAW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ref_append)
            ref_mem[ref_cnt_reg[FAW-1:0]] <= value_reg;
        ref_rdata_reg <= ref_mem[idx_reg[FAW-1:0]];
    end

    assign status.scan_done = scan_done;
    assign status.hit       = hit_reg;
    assign status.res_full  = (res_cnt_reg == RCW'(RESULT_DEPTH));
    assign status.ref_full  = (ref_cnt_reg == FCW'(REFERENCE_DEPTH));
    assign status.second    = second_reg;
    assign status.op_kind   = op_kind_reg;
    assign status.out_free  = out_free;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_ovf_reg;

endmodule

### rtl/set_union_intersection_dedup.sv
// Set union / intersection engine with duplicate removal, signed 32-bit values.
// Input stream s_*: one beat per element; tdata = value, tuser = {restart, from_second}.
// Output stream m_*: one beat per new distinct result; tdata = value_res,
// tuser = overflow (value dropped because its store was full).
// cfg_we/cfg_wdata write op_kind (0 union, 1 intersection); write only while idle.
// Each beat scans its store(s) one entry per cycle through the registered memory
// read port; an intersection first-operand hit scans the reference store and
// then the result store. One beat is in work at a time; s_tready is high only
// between beats. Results sit in an output register; a stalled receiver holds
// the next beat at its emit step until the register frees.
// Reset empties both stores (counts to zero) and sets op_kind to union;
// store contents need no clearing.
module set_union_intersection_dedup #(
    parameter int RESULT_DEPTH    = 64,
    parameter int REFERENCE_DEPTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    input  logic [1:0]  s_tuser,   // [0] from_second, [1] restart
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] value_res
    output logic        m_tuser    // [0] overflow
);
    import suid_pkg::*;

    cmd_t    cmd;
    status_t status;

    suid_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    suid_datapath #(
        .RESULT_DEPTH    (RESULT_DEPTH),
        .REFERENCE_DEPTH (REFERENCE_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .status    (status)
    );

endmodule
